FILE: rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the usual clk_i / rst_ni pair.
`define ASSERT_DEF(label, prop, msg) `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int VAL_W    = 48;
  localparam int STATUS_W = 3;
  localparam int SYM_W    = 8;
  localparam int CNT_W    = 16;

  localparam int STACK_DEPTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] SYM_CR    = 8'h0D;
  localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;

  localparam logic [VAL_W-1:0] VAL_MAXP = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MAXN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_MALFORMED = 3'd1,
    STS_STACK     = 3'd2,
    STS_DIV_ZERO  = 3'd3,
    STS_SAT       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_OP_RD,
    CTL_OP_EX,
    CTL_FIN_RD,
    CTL_FIN_OUT
  } ctl_state_e;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_MUL,
    ALU_DIV,
    ALU_FIN,
    ALU_DONE
  } alu_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic div_zero;
  } alu_rsp_t;

endpackage

FILE: rtl/rpn_stack.sv
module rpn_stack #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]    wr_addr_i,
  input  logic [rpn_pkg::VAL_W-1:0]         wr_data_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]    rd_addr_a_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]    rd_addr_b_i,
  output logic [rpn_pkg::VAL_W-1:0]         rd_data_a_o,
  output logic [rpn_pkg::VAL_W-1:0]         rd_data_b_o
);
  import rpn_pkg::*;

  logic [VAL_W-1:0] mem_q [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Both read ports are always on; read data is registered and lands in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

FILE: rtl/rpn_alu.sv
module rpn_alu #(
  parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rpn_pkg::alu_req_t         req_i,
  input  logic [rpn_pkg::VAL_W-1:0] lhs_i,
  input  logic [rpn_pkg::VAL_W-1:0] rhs_i,
  output rpn_pkg::alu_rsp_t         rsp_o,
  output logic [rpn_pkg::VAL_W-1:0] result_o
);
  import rpn_pkg::*;

  localparam int QW = VAL_W + FRACTION_BITS;  // quotient bits, integer plus fraction
  localparam int CW = $clog2(QW + 1);

  alu_state_e         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  alu_op_e            op_q, op_d;
  logic               neg_q, neg_d;
  logic [VAL_W-1:0]   ma_q, ma_d;
  logic [VAL_W-1:0]   mb_q, mb_d;
  logic [2*VAL_W-1:0] prod_q, prod_d;
  logic [VAL_W-1:0]   rem_q, rem_d;
  logic [QW-1:0]      dq_q, dq_d;
  logic [VAL_W-1:0]   res_q, res_d;
  logic               sat_q, sat_d;
  logic               dz_q, dz_d;

  logic [VAL_W-1:0]   mag_l, mag_r;
  logic [VAL_W+1:0]   sx_l, sx_r, sum;
  logic               sum_ovf;
  logic [VAL_W:0]     mul_sum;
  logic [VAL_W:0]     trial;
  logic               fits;
  logic [VAL_W-1:0]   rem_next;
  logic [VAL_W-1:0]   lim;
  logic [2*VAL_W-1:0] mul_full;
  logic               mul_over, div_over, fin_over;
  logic [VAL_W-1:0]   fin_mag;

  always_comb begin
    mag_l = lhs_i[VAL_W-1] ? (~lhs_i + 1'b1) : lhs_i;
    mag_r = rhs_i[VAL_W-1] ? (~rhs_i + 1'b1) : rhs_i;
    sx_l  = {{2{lhs_i[VAL_W-1]}}, lhs_i};
    sx_r  = {{2{rhs_i[VAL_W-1]}}, rhs_i};
    sum   = (req_i.op == OP_SUB) ? (sx_l - sx_r) : (sx_l + sx_r);
    // top three bits disagree: outside the 48-bit range
    sum_ovf = !((&sum[VAL_W+1:VAL_W-1]) || (~|sum[VAL_W+1:VAL_W-1]));

    // shift-add multiply, one multiplier bit per step
    mul_sum = {1'b0, prod_q[2*VAL_W-1:VAL_W]} + (prod_q[0] ? {1'b0, ma_q} : '0);

    // restoring divide, one quotient bit per step
    trial    = {rem_q, dq_q[QW-1]};
    fits     = trial >= {1'b0, mb_q};
    rem_next = fits ? VAL_W'(trial - {1'b0, mb_q}) : trial[VAL_W-1:0];

    lim      = neg_q ? VAL_MAXN : VAL_MAXP;
    mul_full = prod_q >> FRACTION_BITS;
    mul_over = mul_full > {{VAL_W{1'b0}}, lim};
    div_over = dq_q > QW'(lim);
    if (op_q == OP_MUL) begin
      fin_over = mul_over;
      fin_mag  = mul_over ? lim : mul_full[VAL_W-1:0];
    end else begin
      fin_over = div_over;
      fin_mag  = div_over ? lim : dq_q[VAL_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    neg_d   = neg_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    res_d   = res_q;
    sat_d   = sat_q;
    dz_d    = dz_q;
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          neg_d = lhs_i[VAL_W-1] ^ rhs_i[VAL_W-1];
          ma_d  = mag_l;
          mb_d  = mag_r;
          cnt_d = '0;
          sat_d = 1'b0;
          dz_d  = 1'b0;
          case (req_i.op)
            OP_ADD, OP_SUB: begin
              sat_d   = sum_ovf;
              res_d   = sum_ovf ? (sum[VAL_W+1] ? VAL_MAXN : VAL_MAXP) : sum[VAL_W-1:0];
              state_d = ALU_DONE;
            end
            OP_MUL: begin
              prod_d  = {{VAL_W{1'b0}}, mag_r};
              state_d = ALU_MUL;
            end
            default: begin
              if (mag_r == '0) begin
                res_d   = '0;
                dz_d    = 1'b1;
                state_d = ALU_DONE;
              end else begin
                rem_d   = '0;
                dq_d    = QW'(mag_l) << FRACTION_BITS;
                state_d = ALU_DIV;
              end
            end
          endcase
        end
      end
      ALU_MUL: begin
        prod_d = {mul_sum, prod_q[VAL_W-1:1]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CW'(VAL_W - 1)) begin
          state_d = ALU_FIN;
        end
      end
      ALU_DIV: begin
        rem_d = rem_next;
        dq_d  = {dq_q[QW-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          state_d = ALU_FIN;
        end
      end
      ALU_FIN: begin
        sat_d   = fin_over;
        res_d   = neg_q ? (~fin_mag + 1'b1) : fin_mag;
        state_d = ALU_DONE;
      end
      ALU_DONE: begin
        state_d = ALU_IDLE;
      end
      default: begin
        state_d = ALU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    op_q   <= op_d;
    neg_q  <= neg_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    res_q  <= res_d;
    sat_q  <= sat_d;
    dz_q   <= dz_d;
  end

  assign rsp_o.done     = (state_q == ALU_DONE);
  assign rsp_o.sat      = sat_q;
  assign rsp_o.div_zero = dz_q;
  assign result_o       = res_q;

endmodule

FILE: rtl/postfix_expression_evaluator.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------
// in       | sink      | in_valid_i / in_stall_o | symbol_i[7:0], last_symbol_i
// out      | source    | out_valid_o/out_stall_i | result_value_o[47:0], status_o[2:0]
//
// Timing: whitespace, digits and other operand characters are taken without a stall; an
// operator with two stack entries goes through stack read, ALU and write back, with 48
// shift-add steps for * and one restoring-divide step per quotient bit in the ALU for /.
// The last character adds the top-of-stack read before the result transfer.
// Reset clears pointer, counters, status and control; stack memory is not cleared.
// The result sits in an output register; a stall there only holds the block once the
// next expression is ready to finish.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rpn_pkg::SYM_W-1:0]           symbol_i,
  input  logic                                last_symbol_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rpn_pkg::VAL_W-1:0]    result_value_o,
  output logic [rpn_pkg::STATUS_W-1:0]        status_o
);
  import rpn_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);      // stack address
  localparam int SPW = $clog2(STACK_DEPTH + 1);  // pointer can hold the depth itself

  ctl_state_e        state_q, state_d;
  logic [SPW-1:0]    sp_q, sp_d;
  logic [CNT_W-1:0]  optr_q, optr_d;
  logic [CNT_W-1:0]  opnd_q, opnd_d;
  status_e           sticky_q, sticky_d;
  alu_op_e           op_q, op_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;

  logic              accept;
  logic              is_space, is_op, is_digit;
  alu_op_e           sym_op;
  logic [SPW-1:0]    sp_m1, sp_m2;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [VAL_W-1:0]  rd_top, rd_next;
  logic [VAL_W-1:0]  push_val;
  logic [SYM_W-1:0]  digit;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [VAL_W-1:0]  alu_res;
  logic              malformed;
  status_e           fin_fault, fin_status;

  assign accept = in_valid_i && !in_stall_o;
  assign sp_m1  = sp_q - 1'b1;
  assign sp_m2  = sp_q - 2'd2;
  assign digit  = symbol_i - SYM_ZERO;
  assign push_val = VAL_W'(digit[3:0]) << FRACTION_BITS;

  // character classes
  always_comb begin
    is_space = (symbol_i inside {[SYM_TAB:SYM_CR], SYM_SPACE});
    is_digit = (symbol_i inside {[SYM_ZERO:SYM_NINE]});
    is_op    = 1'b1;
    case (symbol_i)
      SYM_PLUS:  sym_op = OP_ADD;
      SYM_MINUS: sym_op = OP_SUB;
      SYM_STAR:  sym_op = OP_MUL;
      SYM_SLASH: sym_op = OP_DIV;
      default: begin
        sym_op = OP_ADD;
        is_op  = 1'b0;
      end
    endcase
  end

  // end-of-expression status: count check first, then first fault seen
  always_comb begin
    malformed = ({1'b0, opnd_q} != ({1'b0, optr_q} + 1'b1));
    if (sticky_q != STS_OK) begin
      fin_fault = sticky_q;
    end else if (sp_q == '0) begin
      fin_fault = STS_STACK;
    end else begin
      fin_fault = STS_OK;
    end
    fin_status = malformed ? STS_MALFORMED : fin_fault;
  end

  rpn_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_addr_a_i(sp_m1[AW-1:0]),
    .rd_addr_b_i(sp_m2[AW-1:0]),
    .rd_data_a_o(rd_top),
    .rd_data_b_o(rd_next)
  );

  rpn_alu #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .lhs_i   (rd_next),
    .rhs_i   (rd_top),
    .rsp_o   (alu_rsp),
    .result_o(alu_res)
  );

  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    optr_d       = optr_q;
    opnd_d       = opnd_q;
    sticky_d     = sticky_q;
    op_d         = op_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    wr_addr      = sp_q[AW-1:0];
    wr_data      = push_val;
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    in_stall_o   = (state_q != CTL_IDLE);

    case (state_q)
      CTL_IDLE: begin
        if (accept) begin
          last_d  = last_symbol_i;
          state_d = last_symbol_i ? CTL_FIN_RD : CTL_IDLE;
          if (!is_space) begin
            if (is_op) begin
              if (optr_q != '1) begin
                optr_d = optr_q + 1'b1;
              end
              if (sp_q < SPW'(2)) begin
                if (sticky_q == STS_OK) sticky_d = STS_STACK;
              end else begin
                op_d    = sym_op;
                state_d = CTL_OP_RD;   // operand reads were issued at this edge
              end
            end else begin
              if (opnd_q != '1) begin
                opnd_d = opnd_q + 1'b1;
              end
              if (is_digit) begin
                if (sp_q == SPW'(STACK_DEPTH)) begin
                  if (sticky_q == STS_OK) sticky_d = STS_STACK;
                end else begin
                  wr_en = 1'b1;
                  sp_d  = sp_q + 1'b1;
                end
              end
            end
          end
        end
      end
      CTL_OP_RD: begin
        alu_req.start = 1'b1;
        state_d       = CTL_OP_EX;
      end
      CTL_OP_EX: begin
        if (alu_rsp.done) begin
          // pop two, push one: result lands where the left operand was
          wr_en   = 1'b1;
          wr_addr = sp_m2[AW-1:0];
          wr_data = alu_res;
          sp_d    = sp_m1;
          if (sticky_q == STS_OK) begin
            if (alu_rsp.div_zero) begin
              sticky_d = STS_DIV_ZERO;
            end else if (alu_rsp.sat) begin
              sticky_d = STS_SAT;
            end
          end
          state_d = last_q ? CTL_FIN_RD : CTL_IDLE;
        end
      end
      CTL_FIN_RD: begin
        state_d = CTL_FIN_OUT;  // top-of-stack read in flight
      end
      CTL_FIN_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = fin_status;
          if (((fin_status == STS_OK) || (fin_status == STS_SAT)) && (sp_q != '0)) begin
            out_value_d = rd_top;
          end else begin
            out_value_d = '0;
          end
          sp_d     = '0;
          optr_d   = '0;
          opnd_d   = '0;
          sticky_d = STS_OK;
          state_d  = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      sp_q        <= '0;
      optr_q      <= '0;
      opnd_q      <= '0;
      sticky_q    <= STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      optr_q      <= optr_d;
      opnd_q      <= opnd_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    last_q       <= last_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

endmodule

FILE: rtl/rpn_checker.sv
`include "assert_macros.svh"

module rpn_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [rpn_pkg::SYM_W-1:0]          symbol_i,
  input logic                               last_symbol_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [rpn_pkg::VAL_W-1:0]   result_value_o,
  input logic [rpn_pkg::STATUS_W-1:0]       status_o
);
  import rpn_pkg::*;

  logic                        in_xfer;
  logic                        sym_is_op;
  logic                        out_held;
  logic                        err_sts;
  logic [VAL_W+STATUS_W-1:0]   out_word;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign sym_is_op = (symbol_i == SYM_PLUS) || (symbol_i == SYM_MINUS) ||
                     (symbol_i == SYM_STAR) || (symbol_i == SYM_SLASH);
  assign out_held  = out_valid_o && out_stall_i;
  assign err_sts   = (status_o != STS_OK) && (status_o != STS_SAT);
  assign out_word  = {result_value_o, status_o};

  // held result must not move while the sink stalls
  `ASSERT_DEF(a_out_hold, out_held |=> out_valid_o && $stable(out_word), "result moved")

  // error statuses carry a zero value
  `ASSERT_DEF(a_err_zero, out_valid_o && err_sts |-> result_value_o == '0, "error value")

  // closing an expression always takes the stack-top read cycle
  `ASSERT_DEF(a_last_stall, in_xfer && last_symbol_i |=> in_stall_o, "no stall after last")

  // a non-operator that does not close the expression causes no stall
  `ASSERT_DEF(a_opnd_fast, in_xfer && !last_symbol_i && !sym_is_op |=> !in_stall_o, "slow")

  // only defined status codes leave the block
  `ASSERT_DEF(a_sts_range, out_valid_o |-> status_o <= STS_SAT, "status out of range")

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (.*);

FILE: tb/postfix_expression_evaluator_tb.sv
module postfix_expression_evaluator_tb;
  import rpn_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int FRAC         = FRACTION_BITS_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 100;   // longer than the slowest divide plus readout
  localparam int DIR_N        = 24;

  // Magnitude limits and the divide early-out threshold, all 64-bit.
  localparam logic [63:0] POS_LIMIT = {16'd0, VAL_MAXP};
  localparam logic [63:0] NEG_LIMIT = {16'd0, VAL_MAXN};
  localparam logic [63:0] QUOT_BIG  = {15'd0, VAL_MAXN, 1'b0};

  typedef logic signed [VAL_W-1:0] fx_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    status_e          sts;
  } result_t;

  // One row of the directed part. Rows with typed set carry the expected
  // result by hand; all others are checked against the predictor.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             typed;
    logic [VAL_W-1:0] val;
    status_e          sts;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [SYM_W-1:0]         symbol_i;
  logic                     last_symbol_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [VAL_W-1:0]  result_value_o;
  logic [STATUS_W-1:0]      status_o;

  // Predictor state.
  fx_t          model_stack [DEPTH];
  int           model_sp;
  logic [15:0]  model_ops;
  logic [15:0]  model_opnds;
  status_e      model_sticky;

  result_t          pending_results [$];
  logic [SYM_W-1:0] expr_q [$];

  int fail_count;
  int sent_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  dir_row_t dir_rows [DIR_N] = '{
    '{SYM_NINE,  1, 1, 48'h0000_0009_0000, STS_OK},        // single digit
    '{SYM_PLUS,  1, 1, 48'h0,              STS_MALFORMED}, // lone operator
    '{SYM_ZERO,  0, 0, 48'h0,              STS_OK},        // 0 / 0
    '{SYM_CR,    0, 0, 48'h0,              STS_OK},
    '{SYM_ZERO,  0, 0, 48'h0,              STS_OK},
    '{SYM_SLASH, 1, 1, 48'h0,              STS_DIV_ZERO},
    '{SYM_NINE,  0, 0, 48'h0,              STS_OK},        // 9 8 -
    '{8'h38,     0, 0, 48'h0,              STS_OK},
    '{SYM_MINUS, 1, 0, 48'h0,              STS_OK},
    '{8'h38,     0, 0, 48'h0,              STS_OK},        // 8 9 -, negative
    '{SYM_NINE,  0, 0, 48'h0,              STS_OK},
    '{SYM_MINUS, 1, 0, 48'h0,              STS_OK},
    '{8'h78,     1, 1, 48'h0,              STS_STACK},     // 'x': operand, no push
    '{SYM_TAB,   1, 1, 48'h0,              STS_MALFORMED}, // blank marked last
    '{8'h37,     0, 0, 48'h0,              STS_OK},        // 7 2 *
    '{8'h32,     0, 0, 48'h0,              STS_OK},
    '{SYM_STAR,  1, 0, 48'h0,              STS_OK},
    '{8'h37,     0, 0, 48'h0,              STS_OK},        // 7 3 /, truncation
    '{8'h33,     0, 0, 48'h0,              STS_OK},
    '{SYM_SLASH, 1, 0, 48'h0,              STS_OK},
    '{8'hFF,     1, 1, 48'h0,              STS_STACK},     // top symbol code
    '{8'h00,     1, 1, 48'h0,              STS_STACK},     // bottom symbol code
    '{8'h34,     0, 0, 48'h0,              STS_OK},        // blank ends expression
    '{SYM_SPACE, 1, 1, 48'h0000_0004_0000, STS_OK}
  };

  postfix_expression_evaluator #(
    .STACK_DEPTH   (DEPTH),
    .FRACTION_BITS (FRAC)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_i       (symbol_i),
    .last_symbol_i  (last_symbol_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Only the first fault of an expression sticks.
  function automatic void note_fault(status_e code);
    if (model_sticky == STS_OK) model_sticky = code;
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit is_blank(logic [SYM_W-1:0] sym);
    return (sym == SYM_SPACE) || (sym >= SYM_TAB && sym <= SYM_CR);
  endfunction

  function automatic fx_t fx_clamp(bit neg, logic [63:0] mag, bit over);
    logic [63:0] lim;
    logic [63:0] t;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    if (over || mag > lim) begin
      mag = lim;
      note_fault(STS_SAT);
    end
    t = neg ? (~mag + 64'd1) : mag;
    return t[VAL_W-1:0];
  endfunction

  // b is 64-bit so that the negated most negative value still fits.
  function automatic fx_t fx_add(fx_t a, longint b);
    longint s;
    s = longint'(a) + b;
    return fx_clamp(s < 0, mag64(s), 1'b0);
  endfunction

  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic [127:0] prod;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    prod = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    prod = prod >> FRAC;
    return fx_clamp(neg, prod[63:0], |prod[127:64]);
  endfunction

  // Integer quotient first, then one restoring step per fraction bit; the
  // quotient stops growing once it is clearly out of range.
  function automatic fx_t fx_div(fx_t a, fx_t b);
    logic [63:0] ma, mb, q, r;
    bit          neg, big, qbit;
    neg = (a < 0) != (b < 0);
    ma  = mag64(a);
    mb  = mag64(b);
    if (mb == 64'd0) begin
      note_fault(STS_DIV_ZERO);
      return '0;
    end
    q   = ma / mb;
    r   = ma % mb;
    big = 1'b0;
    for (int i = 0; i < FRAC; i++) begin
      r    = r << 1;
      qbit = 1'b0;
      if (r >= mb) begin
        r    = r - mb;
        qbit = 1'b1;
      end
      if (!big) begin
        q = {q[62:0], qbit};
        if (q > QUOT_BIG) big = 1'b1;
      end
    end
    return fx_clamp(neg, q, big);
  endfunction

  // A push onto a full stack is dropped.
  function automatic void model_push(fx_t v);
    if (model_sp >= DEPTH) begin
      note_fault(STS_STACK);
    end else begin
      model_stack[model_sp] = v;
      model_sp++;
    end
  endfunction

  function automatic void model_clear();
    foreach (model_stack[i]) model_stack[i] = '0;
    model_sp     = 0;
    model_ops    = '0;
    model_opnds  = '0;
    model_sticky = STS_OK;
  endfunction

  // Advances the predictor by one accepted symbol; done flags a result.
  function automatic void eval_symbol(logic [SYM_W-1:0] sym, logic last,
                                      output bit done, output result_t res);
    bit      is_op;
    fx_t     lhs, rhs, val;
    status_e sts;
    done  = 1'b0;
    res   = '0;
    is_op = sym inside {SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH};
    if (!is_blank(sym)) begin
      if (is_op) begin
        if (model_ops != 16'hFFFF) model_ops++;
        if (model_sp < 2) begin
          // too few entries: stack left as is
          note_fault(STS_STACK);
        end else begin
          rhs      = model_stack[model_sp-1];
          lhs      = model_stack[model_sp-2];
          model_sp = model_sp - 2;
          case (sym)
            SYM_PLUS:  val = fx_add(lhs, longint'(rhs));
            SYM_MINUS: val = fx_add(lhs, -longint'(rhs));
            SYM_STAR:  val = fx_mul(lhs, rhs);
            default:   val = fx_div(lhs, rhs);
          endcase
          model_push(val);
        end
      end else begin
        if (model_opnds != 16'hFFFF) model_opnds++;
        if (sym >= SYM_ZERO && sym <= SYM_NINE)
          model_push(fx_t'({40'd0, sym - SYM_ZERO}) << FRAC);
      end
    end
    if (last) begin
      if (int'(model_opnds) != int'(model_ops) + 1) begin
        sts = STS_MALFORMED;
      end else begin
        if (model_sp == 0) note_fault(STS_STACK);
        sts = model_sticky;
      end
      res.val = ((sts == STS_OK || sts == STS_SAT) && model_sp > 0) ?
                model_stack[model_sp-1] : '0;
      res.sts = sts;
      done    = 1'b1;
      model_clear();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Entered just after a rising edge; returns at the edge of the transfer.
  // Valid and payload move only at falling edges, once per edge.
  task automatic send_symbol(logic [SYM_W-1:0] sym, logic last, bit typed,
                             result_t typed_res);
    bit      done;
    result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    symbol_i      <= sym;
    last_symbol_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    eval_symbol(sym, last, done, res);
    if (done) pending_results = {pending_results, (typed ? typed_res : res)};
    sent_count++;
  endtask

  // Sender pause: drop valid, then wait for every pending result.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SYM_W-1:0] rand_op();
    case ($urandom_range(3))
      0:       return SYM_PLUS;
      1:       return SYM_MINUS;
      2:       return SYM_STAR;
      default: return SYM_SLASH;
    endcase
  endfunction

  // Appends one character, sometimes after a random blank.
  task automatic push_char(logic [SYM_W-1:0] c);
    int pick;
    if ($urandom_range(3) == 0) begin
      pick = $urandom_range(5);
      expr_q = {expr_q, ((pick == 5) ? SYM_SPACE : SYM_TAB + 8'(pick))};
    end
    expr_q = {expr_q, c};
  endtask

  // Well-formed expression with n digits; op_pct sets how eagerly operators
  // are taken once two entries are available, so low values build deep stacks.
  task automatic add_formula(int n, int op_pct);
    int depth, pushed;
    depth  = 0;
    pushed = 0;
    while (pushed < n || depth > 1) begin
      if (pushed < n && (depth < 2 || $urandom_range(99) >= op_pct)) begin
        push_char(SYM_ZERO + 8'($urandom_range(9)));
        pushed++;
        depth++;
      end else begin
        push_char(rand_op());
        depth--;
      end
    end
  endtask

  task automatic build_expression();
    int roll, k, m;
    expr_q.delete();
    roll = $urandom_range(99);
    if (roll < 60) begin
      if ($urandom_range(9) == 0) add_formula($urandom_range(12, 20), 15);
      else                        add_formula($urandom_range(1, 6), 50);
    end else if (roll < 75) begin
      if ($urandom_range(3) == 0) begin
        // 9^m divided by 1/9^k: the quotient overruns for large m and k
        m = $urandom_range(2, 9);
        k = $urandom_range(3, 6);
        push_char(SYM_NINE);
        repeat (m - 1) begin
          push_char(SYM_NINE);
          push_char(SYM_STAR);
        end
        push_char(SYM_ZERO + 8'd1);
        repeat (k) begin
          push_char(SYM_NINE);
          push_char(SYM_SLASH);
        end
        push_char(SYM_SLASH);
      end else begin
        // left-leaning chain, mostly multiplies, to hit saturation
        push_char(SYM_NINE);
        repeat ($urandom_range(3, 14)) begin
          push_char($urandom_range(1) ? SYM_NINE : SYM_ZERO + 8'($urandom_range(9)));
          k = $urandom_range(9);
          push_char((k < 6) ? SYM_STAR : (k < 8) ? SYM_SLASH : rand_op());
        end
      end
    end else if (roll < 88) begin
      // broken: one character overwritten with an arbitrary code
      add_formula($urandom_range(1, 5), 50);
      expr_q[$urandom_range(expr_q.size() - 1)] = 8'($urandom_range(255));
    end else begin
      repeat ($urandom_range(1, 6)) expr_q = {expr_q, 8'($urandom_range(255))};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver stall. A hold-off request is counted down here, cycle by cycle.
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Every result transfer is matched against the oldest pending result.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: value %h status %0d", result_value_o, status_o);
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.val || status_o !== want.sts) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     want.val, want.sts, result_value_o, status_o);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("postfix_expression_evaluator verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    result_t typed_res;
    int      phase;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    symbol_i      = '0;
    last_symbol_i = 1'b0;
    hold_req      = 1'b0;
    fail_count    = 0;
    sent_count    = 0;
    send_idle_pct = 12;
    recv_idle_pct = 51;
    model_clear();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < DIR_N; i++) begin
      typed_res.val = dir_rows[i].val;
      typed_res.sts = dir_rows[i].sts;
      send_symbol(dir_rows[i].sym, dir_rows[i].last, dir_rows[i].typed, typed_res);
    end
    wait_drained();

    // Random part: long receiver hold-off up front while transfers keep coming,
    // then the idling mix changes at each third, with a full drain in between.
    sent_count = 0;
    phase      = 0;
    hold_req   = 1'b1;
    while (sent_count < RANDOM_ITEMS) begin
      if (phase == 0 && sent_count >= RANDOM_ITEMS / 3) begin
        wait_drained();
        send_idle_pct = 51;
        recv_idle_pct = 12;
        phase         = 1;
      end
      if (phase == 1 && sent_count >= 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase         = 2;
      end
      build_expression();
      foreach (expr_q[i])
        send_symbol(expr_q[i], i == expr_q.size() - 1, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("postfix_expression_evaluator verification clean");
    end else begin
      $display("postfix_expression_evaluator verification failed");
    end
    $finish;
  end

endmodule
